### src/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types and constants of the HTTP response size parser: request and
// result payloads, the end-of-buffer summary, outcome codes, character codes.
// ----------------------------------------------------------------------------
package hrsp_pkg;

    localparam int SIZE_BITS  = 32;
    localparam int COUNT_BITS = 16;
    localparam int CFG_BITS   = 16;

    localparam logic [CFG_BITS-1:0]   MAX_HEADER_RESET = CFG_BITS'(8190);
    localparam logic [COUNT_BITS-1:0] STATUS_LEN       = COUNT_BITS'(12);
    localparam logic [3:0]            NAME_LEN         = 4'd14;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    typedef enum logic [1:0] {
        OUT_INCOMPLETE = 2'd0,
        OUT_ERROR      = 2'd1,
        OUT_COMPLETE   = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        t_outcome             outcome;
        logic [SIZE_BITS-1:0] total_size;
        logic [9:0]           status_code;
    } t_out_req;

    // Parser state at the end of one buffer
    typedef struct packed {
        logic                  over_limit;
        logic                  status_valid;
        logic                  header_done;
        logic                  length_found;
        logic [9:0]            status_value;
        logic [SIZE_BITS-1:0]  length_value;
        logic [COUNT_BITS-1:0] header_end_pos;
    } t_snap;

    // Fixed bytes of the status line; positions five and seven are free
    function automatic logic [7:0] status_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h48; // H
            4'd1:    c = 8'h54; // T
            4'd2:    c = 8'h54; // T
            4'd3:    c = 8'h50; // P
            4'd4:    c = 8'h2F; // /
            4'd6:    c = 8'h2E; // .
            4'd8:    c = 8'h20; // space
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Lower-case header name to match
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### src/hrsp_byte_parser.sv
// ----------------------------------------------------------------------------
// hrsp_byte_parser
// Per-byte state update: status line check, header line name match,
// Content-Length value, header end search. Captures a summary on the last
// byte of a buffer and clears its state for the next one.
// ----------------------------------------------------------------------------
module hrsp_byte_parser import hrsp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    input  logic          i_in_valid,
    input  t_in_req       i_in_data,
    output logic          o_in_stall,
    input  logic          i_snap_take,
    output logic          o_snap_valid,
    output t_snap         o_snap
);

    logic [CFG_BITS-1:0]   r_max_header_bytes;
    logic [COUNT_BITS-1:0] r_byte_count,   n_byte_count;
    logic [1:0]            r_crlf,         n_crlf;
    logic                  r_status_ok,    n_status_ok;
    logic [9:0]            r_status_value, n_status_value;
    logic                  r_colon_seen,   n_colon_seen;
    logic                  r_skip,         n_skip;
    logic [3:0]            r_name_pos,     n_name_pos;
    logic                  r_name_match,   n_name_match;
    logic                  r_length_found, n_length_found;
    logic [SIZE_BITS-1:0]  r_length_value, n_length_value;
    logic                  r_value_stop,   n_value_stop;
    logic [COUNT_BITS-1:0] r_header_end,   n_header_end;
    logic                  r_header_done,  n_header_done;
    logic                  r_snap_valid;
    t_snap                 r_snap,         n_snap;

    logic                  w_accept;
    logic [7:0]            w_b;
    logic                  w_prev_cr;
    logic [7:0]            w_lc;
    logic                  w_digit;
    logic [3:0]            w_dval;
    logic [SIZE_BITS+3:0]  w_len_wide;
    logic [13:0]           w_status_wide;

    assign o_in_stall   = r_snap_valid && !i_snap_take;
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_b          = i_in_data.data_byte;
    assign w_prev_cr    = r_crlf[0];
    assign w_lc         = (w_b >= CH_UP_A && w_b <= CH_UP_Z) ? w_b + 8'd32 : w_b;
    assign w_digit      = (w_b >= CH_ZERO && w_b <= CH_NINE);
    assign w_dval       = 4'(w_b - CH_ZERO);
    assign w_len_wide   = (SIZE_BITS+4)'({r_length_value, 3'b000})
                        + (SIZE_BITS+4)'({r_length_value, 1'b0})
                        + (SIZE_BITS+4)'(w_dval);
    assign w_status_wide = 14'({r_status_value, 3'b000}) + 14'({r_status_value, 1'b0})
                         + 14'(w_dval);

    // Next state for one byte
    always_comb begin
        n_byte_count   = r_byte_count;
        n_crlf         = r_crlf;
        n_status_ok    = r_status_ok;
        n_status_value = r_status_value;
        n_colon_seen   = r_colon_seen;
        n_skip         = r_skip;
        n_name_pos     = r_name_pos;
        n_name_match   = r_name_match;
        n_length_found = r_length_found;
        n_length_value = r_length_value;
        n_value_stop   = r_value_stop;
        n_header_end   = r_header_end;
        n_header_done  = r_header_done;

        // Count bytes, saturate
        if (r_byte_count != '1) begin
            n_byte_count = r_byte_count + 1'b1;
        end

        // Status line
        if (r_byte_count < COUNT_BITS'(9)) begin
            if (r_byte_count != COUNT_BITS'(5) && r_byte_count != COUNT_BITS'(7)
                && w_b != status_char(r_byte_count[3:0])) begin
                n_status_ok = 1'b0;
            end
        end else if (r_byte_count < STATUS_LEN) begin
            if (w_digit) begin
                n_status_value = w_status_wide[9:0];
            end else begin
                n_status_ok = 1'b0;
            end
        end

        if (!r_header_done) begin
            // Bare CR ends the value or spoils the name
            if (w_prev_cr && w_b != CH_LF) begin
                if (!r_colon_seen) begin
                    n_name_match = 1'b0;
                end else begin
                    n_value_stop = 1'b1;
                end
            end

            // Header line fields
            if (w_b == CH_LF && w_prev_cr) begin
                if (r_colon_seen && r_name_match && r_name_pos == NAME_LEN
                    && !r_length_found) begin
                    n_length_found = 1'b1;
                end
                n_colon_seen = 1'b0;
                n_skip       = 1'b0;
                n_name_pos   = '0;
                n_name_match = 1'b1;
                n_value_stop = 1'b0;
            end else if (w_b == CH_CR) begin
                // hold
            end else if (!r_colon_seen) begin
                if (w_b == CH_COLON) begin
                    n_colon_seen = 1'b1;
                    n_skip       = 1'b1;
                end else if (r_name_pos < NAME_LEN) begin
                    if (w_lc != name_char(r_name_pos)) begin
                        n_name_match = 1'b0;
                    end
                    n_name_pos = r_name_pos + 1'b1;
                end else begin
                    n_name_match = 1'b0;
                end
            end else if (r_name_match && r_name_pos == NAME_LEN && !r_length_found
                         && !n_value_stop) begin
                if (r_skip && (w_b == CH_SP || w_b == CH_TAB)) begin
                    // skip leading blank
                end else begin
                    n_skip = 1'b0;
                    if (w_digit) begin
                        if (w_len_wide[SIZE_BITS+3:SIZE_BITS] != 4'd0) begin
                            n_length_value = '1;
                        end else begin
                            n_length_value = w_len_wide[SIZE_BITS-1:0];
                        end
                    end else begin
                        n_value_stop = 1'b1;
                    end
                end
            end

            // Header end search
            if (w_b == CH_CR) begin
                n_crlf = (r_crlf == 2'd2) ? 2'd3 : 2'd1;
            end else if (w_b == CH_LF) begin
                if (r_crlf == 2'd3) begin
                    n_header_done = 1'b1;
                    n_header_end  = n_byte_count;
                    n_crlf        = 2'd0;
                end else begin
                    n_crlf = (r_crlf == 2'd1) ? 2'd2 : 2'd0;
                end
            end else begin
                n_crlf = 2'd0;
            end
        end

        // Summary at end of buffer
        n_snap.over_limit     = !n_header_done
                              && (CFG_BITS+COUNT_BITS)'(n_byte_count)
                                 >= (CFG_BITS+COUNT_BITS)'(r_max_header_bytes);
        n_snap.status_valid   = n_status_ok && n_byte_count >= STATUS_LEN;
        n_snap.header_done    = n_header_done;
        n_snap.length_found   = n_length_found;
        n_snap.status_value   = n_status_value;
        n_snap.length_value   = n_length_value;
        n_snap.header_end_pos = n_header_end;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_header_bytes <= MAX_HEADER_RESET;
        end else if (i_cfg_we) begin
            r_max_header_bytes <= i_cfg_wdata;
        end
    end

    // Advance state on each request, clear after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_in_data.last_byte)) begin
            r_byte_count   <= '0;
            r_crlf         <= 2'd0;
            r_status_ok    <= 1'b1;
            r_status_value <= '0;
            r_colon_seen   <= 1'b0;
            r_skip         <= 1'b0;
            r_name_pos     <= '0;
            r_name_match   <= 1'b1;
            r_length_found <= 1'b0;
            r_length_value <= '0;
            r_value_stop   <= 1'b0;
            r_header_end   <= '0;
            r_header_done  <= 1'b0;
        end else if (w_accept) begin
            r_byte_count   <= n_byte_count;
            r_crlf         <= n_crlf;
            r_status_ok    <= n_status_ok;
            r_status_value <= n_status_value;
            r_colon_seen   <= n_colon_seen;
            r_skip         <= n_skip;
            r_name_pos     <= n_name_pos;
            r_name_match   <= n_name_match;
            r_length_found <= n_length_found;
            r_length_value <= n_length_value;
            r_value_stop   <= n_value_stop;
            r_header_end   <= n_header_end;
            r_header_done  <= n_header_done;
        end
    end

    // Summary register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (w_accept && i_in_data.last_byte) begin
            r_snap_valid <= 1'b1;
        end else if (i_snap_take) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.last_byte) begin
            r_snap <= n_snap;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

### src/hrsp_result_stage.sv
// ----------------------------------------------------------------------------
// hrsp_result_stage
// Turns the end-of-buffer summary into outcome, total size and status code,
// and holds the result request until the receiver takes it.
// ----------------------------------------------------------------------------
module hrsp_result_stage import hrsp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_snap_valid,
    input  t_snap    i_snap,
    output logic     o_snap_take,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    logic                 r_out_valid;
    t_out_req             r_out_data, n_out_data;
    logic [SIZE_BITS-1:0] w_base;
    logic [SIZE_BITS-1:0] w_add;
    logic [SIZE_BITS:0]   w_sum;

    assign o_snap_take = !r_out_valid || !i_out_stall;

    assign w_base = SIZE_BITS'(i_snap.header_end_pos);
    assign w_add  = i_snap.length_found ? i_snap.length_value : '0;
    assign w_sum  = {1'b0, w_base} + {1'b0, w_add};

    // Pick the outcome; limit first, then status, then header end
    always_comb begin
        n_out_data.total_size  = '0;
        n_out_data.status_code = i_snap.status_valid ? i_snap.status_value : 10'd0;
        priority if (i_snap.over_limit) begin
            n_out_data.outcome = OUT_ERROR;
        end else if (!i_snap.status_valid) begin
            n_out_data.outcome = i_snap.header_done ? OUT_ERROR : OUT_INCOMPLETE;
        end else if (!i_snap.header_done) begin
            n_out_data.outcome = OUT_INCOMPLETE;
        end else begin
            n_out_data.outcome    = OUT_COMPLETE;
            n_out_data.total_size = w_sum[SIZE_BITS] ? '1 : w_sum[SIZE_BITS-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_snap_take) begin
            r_out_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_take && i_snap_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Outcome is one of the three defined codes
    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.outcome == OUT_INCOMPLETE
                         || r_out_data.outcome == OUT_ERROR
                         || r_out_data.outcome == OUT_COMPLETE))
        else $error("undefined outcome code");

    // Size is reported only for a complete header
    a_size_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.outcome != OUT_COMPLETE) |-> r_out_data.total_size == '0)
        else $error("total size set without complete header");

    // A summary that is not taken stays pending
    a_snap_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_snap_valid && !o_snap_take) |=> i_snap_valid)
        else $error("summary dropped while result held");

    // A held result does not change
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result changed");

endmodule

### src/http_response_size_parser_unit.sv
// ----------------------------------------------------------------------------
// http_response_size_parser_unit
// HTTP response size parser: one byte per request, one result per buffer.
// ----------------------------------------------------------------------------
// Feed the bytes of one buffered HTTP response, one byte per request, and
// mark the final byte with last_byte; one result request follows each marked
// byte and the next byte starts a new buffer. The block takes one byte every
// cycle unless stalled: each byte updates a small set of parser registers.
// The result passes the summary register, then the result register. Input
// stalls only when a summary and a result are both held and the result side
// stalls. The user writes max_header_bytes via i_cfg_we / i_cfg_wdata only
// while no buffer is in progress; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module http_response_size_parser_unit import hrsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  t_in_req     i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_req    o_out_data
);

    logic  w_snap_valid;
    logic  w_snap_take;
    t_snap w_snap;

    // Byte parser and summary register
    hrsp_byte_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_snap_take  (w_snap_take),
        .o_snap_valid (w_snap_valid),
        .o_snap       (w_snap)
    );

    // Outcome and result register
    hrsp_result_stage u_result (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (w_snap_valid),
        .i_snap       (w_snap),
        .o_snap_take  (w_snap_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: HTTP response size parser regression
// Feeds buffered HTTP responses one byte per request, marks the last byte of
// each buffer, and predicts every result from an in-bench parser with its own
// copy of the header limit. Directed buffers cover the status line, header
// name matching, value parsing, saturation and the header limit; random
// buffers, mostly well formed, run under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hrsp_pkg::*;

    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam logic [63:0] SIZE_MAX    = (64'd1 << SIZE_BITS) - 64'd1;
    localparam logic [71:0]  STATUS_TPL = "HTTP/x.x ";
    localparam logic [111:0] NAME_TPL   = "content-length";

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    t_in_req     i_in_data   = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_req    o_out_data;

    http_response_size_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Parser model state
    logic [15:0]          hdr_limit;
    logic [15:0]          rx_count;
    logic [1:0]           eol_phase;
    logic                 status_good;
    logic [9:0]           status_num;
    logic                 in_value;
    logic                 value_lead;
    logic [3:0]           name_idx;
    logic                 name_hit;
    logic                 size_seen;
    logic [SIZE_BITS-1:0] size_value;
    logic [15:0]          head_len;
    logic                 head_done;
    logic                 value_halt;

    t_out_req    verdict_q[$];
    logic [7:0]  msg[$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_req  = 0;
    int hold_left = 0;

    int mismatches      = 0;
    int cycle_count     = 0;
    int bytes_sent      = 0;
    int buffers_sent    = 0;
    int n_complete      = 0;
    int n_error         = 0;
    int n_incomplete    = 0;
    int in_stall_cycles = 0;
    t_out_req want;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    // Clear per-buffer state; the header limit is kept
    function automatic void clear_parse();
        rx_count    = '0;
        eol_phase   = '0;
        status_good = 1'b1;
        status_num  = '0;
        in_value    = 1'b0;
        value_lead  = 1'b0;
        name_idx    = '0;
        name_hit    = 1'b1;
        size_seen   = 1'b0;
        size_value  = '0;
        head_len    = '0;
        head_done   = 1'b0;
        value_halt  = 1'b0;
    endfunction

    // Value digits count only on the first full Content-Length line
    function automatic logic size_armed();
        return in_value && name_hit && name_idx == NAME_LEN && !size_seen;
    endfunction

    // Advance the parser by one byte; a last byte queues the buffer verdict
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        int          pos;
        logic        after_cr;
        logic [7:0]  lc;
        logic [63:0] acc;
        logic        fmt_ok;
        t_out_req    r;
        pos      = int'(rx_count);
        after_cr = eol_phase[0];
        if (rx_count != 16'hFFFF)
            rx_count = rx_count + 16'd1;

        // Status line: fixed characters, then three digits
        if (pos < 9) begin
            if (pos != 5 && pos != 7 && b != STATUS_TPL[8*(8-pos) +: 8])
                status_good = 1'b0;
        end else if (pos < 12) begin
            if (b >= CH_ZERO && b <= CH_NINE)
                status_num = 10'(int'(status_num) * 10 + int'(b - CH_ZERO));
            else
                status_good = 1'b0;
        end

        if (!head_done) begin
            // A CR not followed by LF breaks the name or ends the value
            if (after_cr && b != CH_LF) begin
                if (!in_value)
                    name_hit = 1'b0;
                else
                    value_halt = 1'b1;
            end
            if (after_cr && b == CH_LF) begin
                if (size_armed())
                    size_seen = 1'b1;
                in_value   = 1'b0;
                value_lead = 1'b0;
                name_idx   = '0;
                name_hit   = 1'b1;
                value_halt = 1'b0;
            end else if (b != CH_CR) begin
                if (!in_value) begin
                    if (b == CH_COLON) begin
                        in_value   = 1'b1;
                        value_lead = 1'b1;
                    end else begin
                        lc = (b >= CH_UP_A && b <= CH_UP_Z) ? b + 8'd32 : b;
                        if (name_idx < NAME_LEN) begin
                            if (lc != NAME_TPL[8*(13-int'(name_idx)) +: 8])
                                name_hit = 1'b0;
                            name_idx = name_idx + 4'd1;
                        end else begin
                            name_hit = 1'b0;
                        end
                    end
                end else if (size_armed() && !value_halt
                             && !(value_lead && (b == CH_SP || b == CH_TAB))) begin
                    value_lead = 1'b0;
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        acc = 64'(size_value) * 64'd10 + 64'(b - CH_ZERO);
                        size_value = (acc > SIZE_MAX) ? '1 : acc[SIZE_BITS-1:0];
                    end else begin
                        value_halt = 1'b1;
                    end
                end
            end

            // Track CR LF CR LF
            if (b == CH_CR) begin
                eol_phase = (eol_phase == 2'd2) ? 2'd3 : 2'd1;
            end else if (b == CH_LF) begin
                if (eol_phase == 2'd3) begin
                    head_done = 1'b1;
                    head_len  = rx_count;
                    eol_phase = 2'd0;
                end else begin
                    eol_phase = (eol_phase == 2'd1) ? 2'd2 : 2'd0;
                end
            end else begin
                eol_phase = 2'd0;
            end
        end

        if (last) begin
            fmt_ok       = status_good && rx_count >= STATUS_LEN;
            r.total_size = '0;
            if (!head_done && rx_count >= hdr_limit)
                r.outcome = OUT_ERROR;
            else if (!fmt_ok)
                r.outcome = head_done ? OUT_ERROR : OUT_INCOMPLETE;
            else if (!head_done)
                r.outcome = OUT_INCOMPLETE;
            else begin
                r.outcome = OUT_COMPLETE;
                acc = 64'(head_len) + (size_seen ? 64'(size_value) : 64'd0);
                r.total_size = (acc > SIZE_MAX) ? '1 : acc[SIZE_BITS-1:0];
            end
            r.status_code = fmt_ok ? status_num : 10'd0;
            verdict_q.push_back(r);
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall pattern, long hold-off, checking
    // ------------------------------------------------------------------------

    // Drive result stall; a requested hold-off overrides the random pattern
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each accepted result with the oldest pending verdict
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_stall)
            in_stall_cycles++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: outcome %0d size %0d status %0d",
                             $realtime, o_out_data.outcome, o_out_data.total_size,
                             o_out_data.status_code);
            end else begin
                want = verdict_q.pop_front();
                case (want.outcome)
                    OUT_COMPLETE: n_complete++;
                    OUT_ERROR:    n_error++;
                    default:      n_incomplete++;
                endcase
                if (o_out_data.outcome !== want.outcome
                    || o_out_data.total_size !== want.total_size
                    || o_out_data.status_code !== want.status_code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"[%0t] mismatch: outcome exp %0d got %0d, ",
                                  "size exp %0d got %0d, status exp %0d got %0d"},
                                 $realtime, want.outcome, o_out_data.outcome,
                                 want.total_size, o_out_data.total_size,
                                 want.status_code, o_out_data.status_code);
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles, %0d results pending",
                     CYCLE_LIMIT, verdict_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one byte after random idle cycles and hold it until accepted
    task automatic push_byte(input logic [7:0] b, input logic last);
        t_in_req req;
        req.data_byte = b;
        req.last_byte = last;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        parse_byte(b, last);
        bytes_sent++;
    endtask

    // Send the assembled buffer, last byte marked
    task automatic send_msg();
        for (int k = 0; k < msg.size(); k++)
            push_byte(msg[k], k == msg.size() - 1);
        msg.delete();
        buffers_sent++;
    endtask

    // Drop valid and wait until every result is out and the pipe is empty
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        hdr_limit   = v;
    endtask

    // ------------------------------------------------------------------------
    // Buffer assembly. In text, '~' stands for CR and '^' for LF.
    // ------------------------------------------------------------------------

    function automatic void put_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            if (s[k] == "~")
                msg.push_back(CH_CR);
            else if (s[k] == "^")
                msg.push_back(CH_LF);
            else
                msg.push_back(s[k]);
        end
    endfunction

    // Lower-case letters flipped to upper case at random
    function automatic void put_mixcase(input string s);
        logic [7:0] c;
        for (int k = 0; k < s.len(); k++) begin
            c = s[k];
            if (c >= "a" && c <= "z" && $urandom_range(1) == 1)
                c = c - 8'd32;
            msg.push_back(c);
        end
    endfunction

    function automatic void put_digits(input int n);
        repeat (n) msg.push_back(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void put_letters(input int n);
        repeat (n) msg.push_back(8'($urandom_range(8'h7A, 8'h61)));
    endfunction

    function automatic void put_blanks(input int n);
        repeat (n) msg.push_back($urandom_range(1) ? CH_SP : CH_TAB);
    endfunction

    function automatic void put_noise(input int n);
        repeat (n) msg.push_back(8'($urandom_range(255)));
    endfunction

    // One header line of random kind, CR LF included
    function automatic void put_header_line();
        case ($urandom_range(9))
            0, 1, 2: begin
                put_mixcase("content-length:");
                put_blanks($urandom_range(3));
                put_digits(($urandom_range(9) == 0) ? $urandom_range(12, 9)
                                                    : $urandom_range(4));
                if ($urandom_range(3) == 0)
                    put_noise($urandom_range(3, 1));
            end
            3: begin
                case ($urandom_range(4))
                    0:       put_mixcase("content-lengt:");
                    1:       put_mixcase("content-lengthh:");
                    2:       put_mixcase("content_length:");
                    3:       put_mixcase("content-length :");
                    default: put_mixcase(" content-length:");
                endcase
                put_digits($urandom_range(3, 1));
            end
            4: begin
                put_text("X-");
                put_letters($urandom_range(6, 1));
                put_text(": ");
                put_letters($urandom_range(8));
            end
            5: put_letters($urandom_range(20, 1));
            6: put_noise($urandom_range(8, 1));
            7: begin
                put_mixcase("content~-length: ");
                put_digits($urandom_range(3, 1));
            end
            8: begin
                put_mixcase("content-length: ");
                put_digits($urandom_range(3, 1));
                put_text("~");
                put_digits($urandom_range(2, 1));
            end
            default: begin
                put_mixcase("content-length:");
                put_blanks($urandom_range(3));
                put_letters($urandom_range(3, 1));
            end
        endcase
        put_text("~^");
    endfunction

    // Random buffer: mostly well-formed responses, some cut short, some noise
    function automatic void build_response();
        int shape;
        int cut;
        shape = $urandom_range(99);
        if (shape < 8) begin
            put_noise($urandom_range(30, 1));
            return;
        end
        put_text("HTTP/");
        put_noise(1);
        put_text(".");
        put_noise(1);
        put_text(" ");
        put_digits(3);
        if ($urandom_range(9) == 0)
            msg[$urandom_range(11)] = 8'($urandom_range(255));
        if ($urandom_range(1) == 1)
            put_text(" OK");
        put_text("~^");
        repeat ($urandom_range(4)) put_header_line();
        if (shape < 86) begin
            put_text("~^");
            put_noise($urandom_range(6));
        end
        if (shape >= 78 && shape < 92) begin
            cut = $urandom_range(msg.size(), 1);
            while (msg.size() > cut)
                void'(msg.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_size_basics();
        idle_pct  = 0;
        stall_pct = 0;
        set_limit(MAX_HEADER_RESET);
        put_text("HTTP/1.1 200 OK~^Content-Length: 123~^~^ab");
        send_msg();
        put_text("HTTP/1.1 204~^Server: x~^~^");
        send_msg();
        // Header lines after the blank line are body bytes
        put_text("HTTP/1.0 200 ~^~^Content-Length: 5~^~^");
        send_msg();
        put_text("HTTP/1.1 200 ~^Content-Length: 5~^~~^~^");
        send_msg();
        settle();
    endtask

    task automatic test_header_names();
        put_text("HTTP/1.0 404 X~^cOnTeNt-LeNgTh:\t \t42~^Content-Length: 7~^~^");
        send_msg();
        put_text({"HTTP/1.1 200 ~^Content-Lengthx: 5~^Content-Lengt: 6~^",
                  "Content-Length : 7~^X-Content-Length: 8~^~^"});
        send_msg();
        put_text("HTTP/1.1 200 ~^Content-~Length: 9~^~^");
        send_msg();
        put_text("HTTP/1.1 200 ~^Server: Content-Length: 9~^CONTENT-LENGTH: 11~^~^");
        send_msg();
        settle();
    endtask

    task automatic test_length_values();
        put_text("HTTP/1.1 200 ~^Content-Length: 12 34~^~^");
        send_msg();
        put_text("HTTP/1.1 200 ~^Content-Length:abc~^Content-Length: 9~^~^");
        send_msg();
        put_text("HTTP/1.1 200 ~^Content-Length: 5~6~^~^");
        send_msg();
        // Saturation at and past the top of the size range
        put_text("HTTP/1.1 200 ~^Content-Length: 4294967295~^~^");
        send_msg();
        put_text("HTTP/1.1 200 ~^Content-Length: 4294967296~^~^");
        send_msg();
        put_text("HTTP/1.1 200 ~^Content-Length: 0004294967250~^~^");
        send_msg();
        put_text("HTTP/1.1 200 ~^Content-Length:~^~^");
        send_msg();
        settle();
    endtask

    task automatic test_status_line();
        put_text("HTTQ/1.1 200 ~^~^");
        send_msg();
        put_text("HTTP/1.1 2x0 ~^~^");
        send_msg();
        put_text("HTTP/1.1 200");
        send_msg();
        put_text("HTTP/1.1 20");
        send_msg();
        // Version characters are free
        put_text("HTTP/");
        msg.push_back(8'hFF);
        put_text(".");
        msg.push_back(8'h00);
        put_text(" 999~^~^");
        send_msg();
        put_text("HTTP/1.1 200 OK~^Content-Length: 1");
        send_msg();
        // One-byte buffers
        msg.push_back(8'h00);
        send_msg();
        msg.push_back(8'hFF);
        send_msg();
        settle();
    endtask

    task automatic test_header_limit();
        set_limit(16'd1);
        put_text("H");
        send_msg();
        put_text("HTTP/1.1 200 ~^~^");
        send_msg();
        // Just under and at the limit without a header end
        set_limit(16'd20);
        put_text("HTTP/1.1 200 ");
        put_letters(19 - msg.size());
        send_msg();
        put_text("HTTP/1.1 200 ");
        put_letters(20 - msg.size());
        send_msg();
        settle();
    endtask

    // Hold results off for a long stretch while buffers keep coming
    task automatic test_result_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        set_limit(MAX_HEADER_RESET);
        hold_req = 400;
        repeat (4) begin
            put_noise($urandom_range(3, 1));
            send_msg();
            put_text("HTTP/1.1 200 ~^~^");
            send_msg();
        end
        settle();
    endtask

    task automatic test_random_traffic();
        int bytes0;
        int bufs;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  set_limit(MAX_HEADER_RESET); end
                1: begin idle_pct = 55; stall_pct = 0;  set_limit(16'($urandom_range(60, 12))); end
                2: begin idle_pct = 0;  stall_pct = 55; set_limit(16'hFFFF); end
                default: begin idle_pct = 8; stall_pct = 8; set_limit(16'd1); end
            endcase
            bytes0 = bytes_sent;
            bufs   = 0;
            while (bytes_sent - bytes0 < 40 || bufs < 2) begin
                build_response();
                send_msg();
                bufs++;
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        hdr_limit = MAX_HEADER_RESET;
        clear_parse();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_size_basics();
        test_header_names();
        test_length_values();
        test_status_line();
        test_header_limit();
        test_result_backpressure();
        test_random_traffic();

        $display("Sent %0d buffers, %0d bytes: %0d complete, %0d error, %0d incomplete",
                 buffers_sent, bytes_sent, n_complete, n_error, n_incomplete);
        $display("Header limits 1 to 65535 used; input held off %0d cycles by result stalls",
                 in_stall_cycles);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
